// File: hw/rtl/lobm_pkg.sv
// Shared types, constants and codes for the limit order book matcher.
`default_nettype none
package lobm_pkg;
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IN_W  = 136;
    localparam int OUT_W = 200;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;

    localparam logic [1:0] KIND_TRADE = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] vis;
        logic [31:0] peak;
        logic [31:0] hid;
    } entry_t;

    typedef enum logic [2:0] {
        BK_NONE,
        BK_REMOVE,
        BK_ROTATE,
        BK_INSERT,
        BK_SETFRONT
    } bk_op_t;

    typedef struct packed {
        bk_op_t           op;
        logic [IDX_W-1:0] idx;
        entry_t           ent;
    } bk_cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/lobm_alu.sv
// Shared 32-bit subtract and compare unit.
`default_nettype none
module lobm_alu
    import lobm_pkg::*;
(
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] diff,
    output logic             lt
);
    logic [32:0] full;
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[31:0];
    assign lt   = full[32];
endmodule
`default_nettype wire

// File: hw/rtl/lobm_book.sv
// One side of the book: entries kept best first, shifted in place.
`default_nettype none
module lobm_book
    import lobm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bk_cmd_t          cmd,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                front,
    output entry_t                rd_ent,
    output logic      [CNT_W-1:0] count
);
    entry_t           ent_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;

    assign front  = ent_reg[0];
    assign rd_ent = ent_reg[rd_idx];
    assign count  = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == BK_REMOVE)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
        else if (cmd.op == BK_INSERT)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            BK_REMOVE:
            begin
                for (int j = 0; j < DEPTH - 1; j++)
                begin
                    if (IDX_W'(j) >= cmd.idx)
                    begin
                        ent_reg[j] <= ent_reg[j + 1];
                    end
                end
            end
            BK_ROTATE:
            begin
                // idx is the last slot of the level; refilled front goes there
                for (int j = 0; j < DEPTH - 1; j++)
                begin
                    if (IDX_W'(j) < cmd.idx)
                    begin
                        ent_reg[j] <= ent_reg[j + 1];
                    end
                end
                ent_reg[cmd.idx] <= cmd.ent;
            end
            BK_INSERT:
            begin
                for (int j = 1; j < DEPTH; j++)
                begin
                    if (IDX_W'(j) > cmd.idx)
                    begin
                        ent_reg[j] <= ent_reg[j - 1];
                    end
                end
                ent_reg[cmd.idx] <= cmd.ent;
            end
            BK_SETFRONT:
            begin
                ent_reg[0] <= cmd.ent;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/limit_order_book_matcher.sv
// Latency is data dependent. Each fill step runs setup, a scan of the orders at the
// level and two passes through the shared subtract/compare unit; a traded level then
// emits one trade beat per filled maker. A resting insert scans past the entries ahead
// of it, then inserts; listing emits one beat per book line, done included.
// Throughput: one operation at a time, s_tready high only when idle; output stalls lengthen each operation.
// Reset: asynchronous active low; both books and the fill table read as empty.
`default_nettype none
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // order_id, side, price, quantity, peak (low bits up), zero padded
    input  wire logic [IN_W-1:0]  s_tdata,
    // operation
    input  wire logic [1:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // buyer_id, seller_id, line_id, line_side, deal_price, amount, line_peak,
    // status (low bits up), zero padded
    output logic [OUT_W-1:0]      m_tdata,
    // kind
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);
    typedef enum logic [3:0] {
        S_IDLE, S_LVL, S_STEP, S_LEN, S_T0, S_T1, S_EMIT,
        S_REST, S_POS, S_INS, S_CXL, S_LIST, S_LISTB, S_LISTA, S_DONE
    } state_t;

    state_t           state_reg;
    logic             side_reg, full_reg, cside_reg;
    logic [31:0]      id_reg, price_reg, peak_reg, rem_reg, lp_reg, tv_reg;
    logic [31:0]      vis_new_reg, hid_new_reg;
    logic [CNT_W-1:0] ptr_reg, fill_cnt_reg;
    logic [1:0]       status_reg;
    logic [31:0]      fill_maker_reg [DEPTH];
    logic [31:0]      fill_vol_reg   [DEPTH];

    logic             m_tvalid_reg, m_tlast_reg;
    logic [1:0]       m_tuser_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    bk_cmd_t          cmd [2];
    entry_t           front [2];
    entry_t           rd_ent [2];
    logic [CNT_W-1:0] cnt [2];
    logic [IDX_W-1:0] rd_idx;

    logic [31:0] alu_a, alu_b, alu_diff;
    logic        alu_lt;

    logic             opp;
    entry_t           of, rdo;
    logic             can_emit;
    logic             beat_go;
    logic [31:0]      refill, hid_left;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    lobm_alu u_alu (.a(alu_a), .b(alu_b), .diff(alu_diff), .lt(alu_lt));

    for (genvar g = 0; g < 2; g++)
    begin : g_book
        lobm_book u_book (
            .clk(clk), .rst_n(rst_n), .cmd(cmd[g]), .rd_idx(rd_idx),
            .front(front[g]), .rd_ent(rd_ent[g]), .count(cnt[g])
        );
    end

    assign opp      = ~side_reg;
    assign of       = front[opp];
    assign rdo      = rd_ent[opp];
    assign can_emit = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign rd_idx = (state_reg == S_LISTB) ? IDX_W'(ptr_reg - CNT_W'(1))
                                           : ptr_reg[IDX_W-1:0];

    // a new output beat is loaded this cycle
    always_comb
    begin
        case (state_reg)
            S_EMIT:  beat_go = can_emit && (ptr_reg < fill_cnt_reg);
            S_LISTB: beat_go = can_emit && (ptr_reg != '0);
            S_LISTA: beat_go = can_emit && (ptr_reg < cnt[1]);
            S_DONE:  beat_go = can_emit;
            default: beat_go = 1'b0;
        endcase
    end

    always_comb
    begin
        alu_a = rem_reg;
        alu_b = of.vis;
        case (state_reg)
            S_T1:
            begin
                alu_a = full_reg ? of.hid : of.vis;
                alu_b = full_reg ? of.peak : tv_reg;
            end
            S_REST:
            begin
                alu_a = rem_reg;
                alu_b = peak_reg;
            end
            default:
            begin
            end
        endcase
    end

    // refill = min(peak, hid); hid_left = hid - refill
    assign refill   = alu_lt ? of.hid : of.peak;
    assign hid_left = alu_lt ? 32'd0 : alu_diff;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int f = DEPTH - 1; f >= 0; f--)
        begin
            if (CNT_W'(f) < fill_cnt_reg && fill_maker_reg[f] == of.id)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(f);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            cmd[b].op  = BK_NONE;
            cmd[b].idx = '0;
            cmd[b].ent = of;
        end
        case (state_reg)
            S_T1:
            begin
                if (!full_reg)
                begin
                    cmd[opp].op      = BK_SETFRONT;
                    cmd[opp].ent.vis = alu_diff;
                end
                else if (refill != 32'd0)
                begin
                    cmd[opp].op      = BK_ROTATE;
                    cmd[opp].idx     = IDX_W'(ptr_reg - CNT_W'(1));
                    cmd[opp].ent.vis = refill;
                    cmd[opp].ent.hid = hid_left;
                end
                else
                begin
                    cmd[opp].op = BK_REMOVE;
                end
            end
            S_INS:
            begin
                cmd[side_reg].op  = BK_INSERT;
                cmd[side_reg].idx = ptr_reg[IDX_W-1:0];
                cmd[side_reg].ent = '{id: id_reg, price: price_reg, vis: vis_new_reg,
                                      peak: peak_reg, hid: hid_new_reg};
            end
            S_CXL:
            begin
                if (ptr_reg < cnt[cside_reg] && rd_ent[cside_reg].id == id_reg)
                begin
                    cmd[cside_reg].op  = BK_REMOVE;
                    cmd[cside_reg].idx = ptr_reg[IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            fill_cnt_reg <= '0;
            ptr_reg      <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (m_tready && !beat_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        id_reg     <= s_tdata[31:0];
                        side_reg   <= s_tdata[32];
                        price_reg  <= s_tdata[64:33];
                        rem_reg    <= s_tdata[96:65];
                        peak_reg   <= s_tdata[128:97];
                        status_reg <= ST_OK;
                        ptr_reg    <= '0;
                        cside_reg  <= 1'b0;
                        if (s_tuser == OP_NEW && s_tdata[96:65] != 32'd0)
                        begin
                            state_reg <= S_LVL;
                        end
                        else if (s_tuser == OP_CANCEL)
                        begin
                            state_reg <= S_CXL;
                        end
                        else
                        begin
                            state_reg <= S_LIST;
                        end
                    end
                end
                S_LVL:
                begin
                    if (rem_reg == 32'd0 || cnt[opp] == '0 ||
                        (side_reg == 1'b0 ? of.price > price_reg : of.price < price_reg))
                    begin
                        state_reg <= S_REST;
                    end
                    else
                    begin
                        lp_reg       <= of.price;
                        fill_cnt_reg <= '0;
                        state_reg    <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    ptr_reg <= '0;
                    if (rem_reg != 32'd0 && cnt[opp] != '0 && of.price == lp_reg)
                    begin
                        state_reg <= S_LEN;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_LEN:
                begin
                    if (ptr_reg < cnt[opp] && rdo.price == lp_reg)
                    begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_T0;
                    end
                end
                S_T0:
                begin
                    // rem >= vis: the whole visible part trades
                    full_reg <= !alu_lt;
                    if (!alu_lt)
                    begin
                        tv_reg  <= of.vis;
                        rem_reg <= alu_diff;
                    end
                    else
                    begin
                        tv_reg <= rem_reg;
                    end
                    state_reg <= S_T1;
                end
                S_T1:
                begin
                    if (!full_reg)
                    begin
                        rem_reg <= 32'd0;
                    end
                    if (hit)
                    begin
                        fill_vol_reg[hit_idx] <= fill_vol_reg[hit_idx] + tv_reg;
                    end
                    else if (fill_cnt_reg < CNT_W'(DEPTH))
                    begin
                        fill_maker_reg[fill_cnt_reg[IDX_W-1:0]] <= of.id;
                        fill_vol_reg[fill_cnt_reg[IDX_W-1:0]]   <= tv_reg;
                        fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                    end
                    state_reg <= S_STEP;
                end
                S_EMIT:
                begin
                    if (ptr_reg >= fill_cnt_reg)
                    begin
                        state_reg <= S_LVL;
                    end
                    else if (can_emit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= KIND_TRADE;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {5'd0, ST_OK, 32'd0,
                                         fill_vol_reg[ptr_reg[IDX_W-1:0]], lp_reg,
                                         1'b0, 32'd0,
                                         side_reg ? id_reg : fill_maker_reg[ptr_reg[IDX_W-1:0]],
                                         side_reg ? fill_maker_reg[ptr_reg[IDX_W-1:0]] : id_reg};
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                end
                S_REST:
                begin
                    ptr_reg <= '0;
                    if (rem_reg == 32'd0)
                    begin
                        state_reg <= S_LIST;
                    end
                    else if (cnt[side_reg] >= CNT_W'(DEPTH))
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_LIST;
                    end
                    else
                    begin
                        // rem >= peak: visible part is the peak
                        if (peak_reg != 32'd0 && !alu_lt)
                        begin
                            vis_new_reg <= peak_reg;
                            hid_new_reg <= alu_diff;
                        end
                        else
                        begin
                            vis_new_reg <= rem_reg;
                            hid_new_reg <= 32'd0;
                        end
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (ptr_reg < cnt[side_reg] &&
                        (side_reg == 1'b0 ? rd_ent[0].price >= price_reg
                                          : rd_ent[1].price <= price_reg))
                    begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_INS;
                    end
                end
                S_INS:
                begin
                    state_reg <= S_LIST;
                end
                S_CXL:
                begin
                    if (ptr_reg < cnt[cside_reg])
                    begin
                        if (rd_ent[cside_reg].id == id_reg)
                        begin
                            state_reg <= S_LIST;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + CNT_W'(1);
                        end
                    end
                    else if (!cside_reg)
                    begin
                        cside_reg <= 1'b1;
                        ptr_reg   <= '0;
                    end
                    else
                    begin
                        status_reg <= ST_NOTFOUND;
                        state_reg  <= S_LIST;
                    end
                end
                S_LIST:
                begin
                    ptr_reg   <= cnt[0];
                    state_reg <= S_LISTB;
                end
                S_LISTB:
                begin
                    if (ptr_reg == '0)
                    begin
                        state_reg <= S_LISTA;
                    end
                    else if (can_emit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= KIND_LINE;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {5'd0, ST_OK, rd_ent[0].peak, rd_ent[0].vis,
                                         rd_ent[0].price, 1'b0, rd_ent[0].id, 64'd0};
                        ptr_reg <= ptr_reg - CNT_W'(1);
                    end
                end
                S_LISTA:
                begin
                    if (ptr_reg >= cnt[1])
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (can_emit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= KIND_LINE;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {5'd0, ST_OK, rd_ent[1].peak, rd_ent[1].vis,
                                         rd_ent[1].price, 1'b1, rd_ent[1].id, 64'd0};
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (can_emit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= KIND_DONE;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {5'd0, status_reg, 193'd0};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/lobm_checker.sv
// Port-level checks for the matcher, bound to the top level.
`default_nettype none
module lobm_checker
    import lobm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser,
    input wire logic             m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_DONE)))
        else $error("tlast not on done beat");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an operation runs");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DONE |-> m_tdata[194:193] == ST_OK)
        else $error("status set on a non-done beat");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
